// ===== rtl/otsu_pkg.sv =====
package otsu_pkg;

    // Default width of the bin counters and the pixel count
    localparam int COUNT_BITS_DEF = 20;

    // Gray levels: 8-bit pixels, one histogram bin per level
    localparam int LEVEL_BITS = 8;
    localparam int NUM_BINS   = 256;

    // Highest threshold tried by the scan
    localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = 8'd254;

endpackage

// ===== rtl/otsu_threshold_finder.sv =====
// Pixels: one item per cycle while accepting, histogram read-modify-write in the bin memory
// with forwarding. After the item marked last the scan tries each threshold in turn, skips one
// that leaves a class empty, else uses three shift-add lanes (one multiplier bit per cycle).
// After the result is registered, a pass over all bins clears the bin memory before new pixels.
// Synchronous active-low reset; after reset the same clearing pass runs first.
module otsu_threshold_finder #(
    parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [otsu_pkg::LEVEL_BITS-1:0] i_pixel,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [otsu_pkg::LEVEL_BITS-1:0] o_threshold
);

    localparam int LW  = otsu_pkg::LEVEL_BITS;
    localparam int CW  = COUNT_BITS;        // counts, N, w
    localparam int MW  = CW + LW;           // S, m
    localparam int PW  = 2 * CW + LW;       // S*w, N*m, their difference
    localparam int WPW = 2 * CW;            // w*(N-w)
    localparam int SQW = 2 * PW;            // difference squared
    localparam int XW  = SQW + WPW;         // cross products of the score compare
    localparam int NL  = 3;                 // shift-add lanes

    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // Sequencer states
    localparam logic [3:0] ST_ACC   = 4'd0;
    localparam logic [3:0] ST_DRAIN = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_ACCUM = 4'd3;
    localparam logic [3:0] ST_PQ    = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_CMP   = 4'd6;
    localparam logic [3:0] ST_NEXT  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;
    localparam logic [3:0] ST_CLR   = 4'd9;

    logic [3:0]    r_state;
    logic [3:0]    n_state;

    // Histogram memory and its ports
    logic [CW-1:0] r_hist [otsu_pkg::NUM_BINS];
    logic [CW-1:0] r_rdata;
    logic [LW-1:0] rd_addr;
    logic          mem_we;
    logic [LW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;

    // Pixel path
    logic          in_accept;
    logic          sat;
    logic          r_p1_valid;
    logic [LW-1:0] r_p1_bin;
    logic          r_wr_valid;
    logic [LW-1:0] r_wr_bin;
    logic [CW-1:0] r_wr_data;
    logic [CW-1:0] bin_inc;
    logic [CW-1:0] r_n;
    logic [MW-1:0] r_s;
    logic [LW-1:0] r_clr_addr;

    // Scan
    logic [LW-1:0]  r_t;
    logic [CW-1:0]  r_w;
    logic [MW-1:0]  r_m;
    logic [CW-1:0]  acc_w;
    logic [MW-1:0]  acc_m;
    logic [MW-1:0]  t_times_bin;
    logic           skip;
    logic [PW-1:0]  prod_p;
    logic [PW-1:0]  prod_q;
    logic [PW-1:0]  diff;
    logic [SQW-1:0] sq_now;
    logic [SQW-1:0] r_sq;
    logic [WPW-1:0] r_wp;
    logic           r_have_best;
    logic [LW-1:0]  r_best_level;
    logic [SQW-1:0] r_bsq;
    logic [WPW-1:0] r_bwp;
    logic [SQW-1:0] best_sq_src;
    logic           take_best;

    // Shift-add lanes
    logic [XW-1:0] r_mc  [NL];
    logic [PW-1:0] r_mp  [NL];
    logic [XW-1:0] r_acc [NL];
    logic [XW-1:0] ld_mc [NL];
    logic [PW-1:0] ld_mp [NL];
    logic          lane_ld;
    logic          lanes_idle;
    logic          lanes_run;

    // Output register
    logic          r_out_valid;
    logic [LW-1:0] r_threshold;

    assign o_in_ready  = (r_state == ST_ACC);
    assign in_accept   = i_in_valid && o_in_ready;
    assign sat         = (r_n == CNT_MAX);
    assign o_out_valid = r_out_valid;
    assign o_threshold = r_threshold;

    // Bin update with forwarding of the write that lands on the edge of the read
    assign bin_inc   = ((r_wr_valid && (r_wr_bin == r_p1_bin)) ? r_wr_data : r_rdata) + 1'b1;
    assign rd_addr   = (r_state == ST_ACC) ? i_pixel : r_t;
    assign mem_we    = r_p1_valid || (r_state == ST_CLR);
    assign mem_waddr = r_p1_valid ? r_p1_bin : r_clr_addr;
    assign mem_wdata = r_p1_valid ? bin_inc : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_hist[rd_addr];
    end

    // Cumulative sums of the scan
    assign t_times_bin = MW'(r_t) * MW'(r_rdata);
    assign acc_w       = r_w + r_rdata;
    assign acc_m       = r_m + t_times_bin;
    assign skip        = (acc_w == '0) || (acc_w >= r_n);

    // |S*w - N*m| and the square from the lanes
    assign prod_p      = r_acc[0][PW-1:0];
    assign prod_q      = r_acc[1][PW-1:0];
    assign diff        = (prod_p >= prod_q) ? (prod_p - prod_q) : (prod_q - prod_p);
    assign sq_now      = r_acc[0][SQW-1:0];
    assign best_sq_src = (r_state == ST_SQ) ? sq_now : r_sq;

    assign lanes_idle = (r_mp[0] == '0) && (r_mp[1] == '0) && (r_mp[2] == '0);
    assign lanes_run  = ((r_state == ST_PQ) || (r_state == ST_SQ) || (r_state == ST_CMP))
                        && !lanes_idle;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        lane_ld   = 1'b0;
        take_best = 1'b0;
        for (int i = 0; i < NL; i++) begin
            ld_mc[i] = '0;
            ld_mp[i] = '0;
        end
        unique case (r_state)
            ST_ACC: begin
                if (in_accept && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_RD;
            ST_RD:    n_state = ST_ACCUM;
            ST_ACCUM: begin
                if (skip) begin
                    n_state = ST_NEXT;
                end else begin
                    // S*w, m*N and w*(N-w)
                    lane_ld  = 1'b1;
                    ld_mc[0] = XW'(r_s);
                    ld_mp[0] = PW'(acc_w);
                    ld_mc[1] = XW'(acc_m);
                    ld_mp[1] = PW'(r_n);
                    ld_mc[2] = XW'(acc_w);
                    ld_mp[2] = PW'(r_n - acc_w);
                    n_state  = ST_PQ;
                end
            end
            ST_PQ: begin
                if (lanes_idle) begin
                    if (diff == '0) begin
                        n_state = ST_NEXT;
                    end else begin
                        lane_ld  = 1'b1;
                        ld_mc[0] = XW'(diff);
                        ld_mp[0] = diff;
                        n_state  = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                if (lanes_idle) begin
                    if (!r_have_best) begin
                        take_best = 1'b1;
                        n_state   = ST_NEXT;
                    end else begin
                        // diff^2 * bw(N-bw) against best^2 * w(N-w)
                        lane_ld  = 1'b1;
                        ld_mc[0] = XW'(sq_now);
                        ld_mp[0] = PW'(r_bwp);
                        ld_mc[1] = XW'(r_bsq);
                        ld_mp[1] = PW'(r_wp);
                        n_state  = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (lanes_idle) begin
                    take_best = (r_acc[0] > r_acc[1]);
                    n_state   = ST_NEXT;
                end
            end
            ST_NEXT: n_state = (r_t == otsu_pkg::LAST_LEVEL) ? ST_DONE : ST_RD;
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_CLR;
                end
            end
            ST_CLR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_CLR;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_addr  <= '0;
            r_p1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_n         <= '0;
            r_s         <= '0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= in_accept && !sat;
            if (r_p1_valid) begin
                r_wr_valid <= 1'b1;
            end else if (r_state == ST_CLR) begin
                r_wr_valid <= 1'b0;
            end
            if (in_accept && !sat) begin
                r_n <= r_n + 1'b1;
                r_s <= r_s + MW'(i_pixel);
            end else if (r_state == ST_CLR) begin
                r_n <= '0;
                r_s <= '0;
            end
            if (r_state == ST_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_DRAIN) begin
                r_have_best <= 1'b0;
            end else if (take_best) begin
                r_have_best <= 1'b1;
            end
            if ((r_state == ST_DONE) && (n_state == ST_CLR)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_p1_bin <= i_pixel;
        end
        if (r_p1_valid) begin
            r_wr_bin  <= r_p1_bin;
            r_wr_data <= bin_inc;
        end
        if (r_state == ST_DRAIN) begin
            r_t          <= '0;
            r_w          <= '0;
            r_m          <= '0;
            r_best_level <= '0;
        end
        if (r_state == ST_ACCUM) begin
            r_w <= acc_w;
            r_m <= acc_m;
        end
        if (r_state == ST_NEXT) begin
            r_t <= r_t + 1'b1;
        end
        if ((r_state == ST_PQ) && lanes_idle) begin
            r_wp <= r_acc[2][WPW-1:0];
        end
        if ((r_state == ST_SQ) && lanes_idle) begin
            r_sq <= sq_now;
        end
        if (take_best) begin
            r_best_level <= r_t;
            r_bsq        <= best_sq_src;
            r_bwp        <= r_wp;
        end
        if ((r_state == ST_DONE) && (n_state == ST_CLR)) begin
            r_threshold <= r_best_level;
        end
    end

    // Shift-add lanes: one multiplier bit per cycle, stop when all multipliers run out
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NL; i++) begin
            if (lane_ld) begin
                r_mc[i]  <= ld_mc[i];
                r_mp[i]  <= ld_mp[i];
                r_acc[i] <= '0;
            end else if (lanes_run) begin
                if (r_mp[i][0]) begin
                    r_acc[i] <= r_acc[i] + r_mc[i];
                end
                r_mc[i] <= r_mc[i] << 1;
                r_mp[i] <= r_mp[i] >> 1;
            end
        end
    end

    // A counted pixel is written to its own bin on the next cycle
    a_bin_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (r_n != CNT_MAX))
        |=> (mem_we && (mem_waddr == $past(i_pixel))))
        else $error("pixel bin write missing or misdirected");

    // No pending bin write once the scan or the clearing pass runs
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> ((r_state == ST_ACC) || (r_state == ST_DRAIN)))
        else $error("bin write overlaps scan or clear");

    // A delivered threshold lies within the scanned range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_threshold <= otsu_pkg::LAST_LEVEL))
        else $error("threshold out of range");

endmodule
